// ===== rtl/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and constants of the pair-escape run-length encoder.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam logic [ByteW-1:0] CountMax = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_HELD  = 3'b010,
    PH_COUNT = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
  } res_t;

  // up to two results produced by one item
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

endpackage

// ===== rtl/rpe_if.sv =====
// ----------------------------------------------------------------------------
// rpe_if
// Valid/ready channels for raw input bytes and encoded output bytes.
// ----------------------------------------------------------------------------
interface rpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface rpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/rpe_core.sv =====
// ----------------------------------------------------------------------------
// rpe_core
// Encoder state (phase, held byte, run count) and the per-item result logic.
// ----------------------------------------------------------------------------
module rpe_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [rpe_pkg::ByteW-1:0] data_byte_i,
  input  logic                   block_end_i,
  output rpe_pkg::res_pair_t     res_o
);
  import rpe_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] held_q, held_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] count_inc;
  logic             same;

  assign same      = (data_byte_i == held_q);
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    count_d = count_q;
    res_o   = '0;
    unique case (phase_q)
      PH_HELD: begin
        if (same) begin
          res_o.n  = 2'd2;
          res_o.r0 = '{out_byte: data_byte_i, out_last: 1'b0};
          res_o.r1 = '{out_byte: data_byte_i, out_last: block_end_i};
          count_d  = '0;
          phase_d  = block_end_i ? PH_IDLE : PH_COUNT;
        end else begin
          res_o.r0 = '{out_byte: held_q, out_last: 1'b0};
          if (block_end_i) begin
            res_o.n  = 2'd2;
            res_o.r1 = '{out_byte: data_byte_i, out_last: 1'b1};
            phase_d  = PH_IDLE;
          end else begin
            res_o.n = 2'd1;
            held_d  = data_byte_i;
            phase_d = PH_HELD;
          end
        end
      end
      PH_COUNT: begin
        if (same && (count_q != CountMax)) begin
          if (block_end_i) begin
            res_o.n  = 2'd1;
            res_o.r0 = '{out_byte: count_inc, out_last: 1'b1};
            count_d  = '0;
            phase_d  = PH_IDLE;
          end else begin
            count_d = count_inc;
          end
        end else begin
          res_o.r0 = '{out_byte: count_q, out_last: 1'b0};
          count_d  = '0;
          if (block_end_i) begin
            res_o.n  = 2'd2;
            res_o.r1 = '{out_byte: data_byte_i, out_last: 1'b1};
            phase_d  = PH_IDLE;
          end else begin
            res_o.n = 2'd1;
            held_d  = data_byte_i;
            phase_d = PH_HELD;
          end
        end
      end
      default: begin
        if (block_end_i) begin
          res_o.n  = 2'd1;
          res_o.r0 = '{out_byte: data_byte_i, out_last: 1'b1};
          phase_d  = PH_IDLE;
        end else begin
          held_d  = data_byte_i;
          phase_d = PH_HELD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== rtl/rpe_out_q.sv =====
// ----------------------------------------------------------------------------
// rpe_out_q
// Small result queue: takes up to two results per cycle, drains one while the output is ready.
// ----------------------------------------------------------------------------
module rpe_out_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rpe_pkg::res_pair_t res_i,
  output logic               room2_o,
  rpe_out_if.source          out_o
);
  import rpe_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q, wr1;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] push_n;
  logic             pop;

  assign push_n  = push_i ? QCntW'(res_i.n) : '0;
  assign pop     = out_o.valid && out_o.ready;
  assign cnt_d   = cnt_q + push_n - QCntW'(pop);
  assign wr1     = wr_q + QPtrW'(1);
  assign room2_o = (cnt_q <= QCntW'(QDepth - 2));

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = mem_q[rd_q].out_byte;
  assign out_o.out_last = mem_q[rd_q].out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_n);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (res_i.n != 2'd0)) begin
      mem_q[wr_q] <= res_i.r0;
    end
    if (push_i && (res_i.n == 2'd2)) begin
      mem_q[wr1] <= res_i.r1;
    end
  end

endmodule

// ===== rtl/rle_pair_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// rle_pair_escape_encoder
// Byte-stream run-length encoder with doubled-byte escape and count byte.
// ----------------------------------------------------------------------------
// An input item is registered, then encoded from that register into zero,
// one or two output bytes that enter a four-entry result queue. Input is
// taken every cycle while the queue has room for two results, so items that
// yield at most one byte sustain one item per cycle while the output is ready
// and a stream of items that each yield two bytes is held to the pace of the
// one-byte output channel. An item's output bytes are read from the result
// queue after the item has passed the input register and the encoder.
// ----------------------------------------------------------------------------
module rle_pair_escape_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpe_in_if.sink     in_i,
  rpe_out_if.source  out_o
);
  import rpe_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;
  logic             room2;
  logic             fire;
  res_pair_t        res;

  assign fire       = in_vld_q && room2;
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.block_end;
    end
  end

  rpe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (in_byte_q),
    .block_end_i (in_end_q),
    .res_o       (res)
  );

  rpe_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .res_i   (res),
    .room2_o (room2),
    .out_o   (out_o)
  );

endmodule
